FILE: rtl/core/tnfa_pkg.sv
`default_nettype none
package tnfa_pkg;
  typedef enum logic [1:0] {
    CMD_BUILD   = 2'd0,
    CMD_CLOSURE = 2'd1,
    CMD_STEP    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_FULL  = 2'd2,
    ST_STACK = 2'd3
  } status_t;

  localparam logic [7:0] CH_CAT  = 8'h2E;
  localparam logic [7:0] CH_ALT  = 8'h7C;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_PLUS = 8'h2B;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the input word
    logic clr_init;  // reset stack and counters, start a sweep at entry 0
    logic clr_row;   // clear current sweep row
    logic build;     // apply build for latched character
    logic op_rd;     // read the row of the next lambda update
    logic op_wb;     // write back that row with the new edges
    logic scan_init; // start a set scan
    logic scan_row;  // one scan step
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic op_pend;
    logic is_query;
    logic is_clear;
  } dp_stat_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/thompson_nfa_builder.sv
// Work per word: a build updates one lambda row at a time, each read then
//   written back (concatenation 1 row, star or plus 2, alternation 3); a step
//   query scans all MAX_STATES rows; a closure visits each state reached.
// Throughput: one word at a time; input is ready again in the cycle after the
//   result is taken, and after a clear only once its MAX_STATES-row sweep ends.
// Reset: rst synchronous; all MAX_STATES edge table rows swept clear first.
`default_nettype none
module thompson_nfa_builder #(
  parameter int MAX_STATES  = 64,
  parameter int STACK_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,  // cmd, symbol, query_set
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata   // status, result_set, start_state, accept_state, stack_depth
);
  tnfa_pkg::dp_cmd_t  cmd;
  tnfa_pkg::dp_stat_t stat;

  tnfa_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .m_tready, .m_tvalid, .stat, .cmd
  );
  tnfa_dp #(.MAX_STATES(MAX_STATES), .STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk, .in_word(s_tdata), .cmd, .stat, .out_word(m_tdata)
  );
endmodule
`default_nettype wire

FILE: rtl/core/tnfa_ctrl.sv
`default_nettype none
module tnfa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic              m_tready,
  output logic                   m_tvalid,
  input  wire tnfa_pkg::dp_stat_t stat,
  output tnfa_pkg::dp_cmd_t      cmd
);
  typedef enum logic [2:0] {
    S_RESET, S_CLR, S_IDLE, S_DISPATCH, S_WRD, S_WWB, S_SCAN, S_OUT
  } state_t;
  state_t state;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load      = (state == S_IDLE) && s_tvalid;
    cmd.clr_init  = ((state == S_DISPATCH) && stat.is_clear) || (state == S_RESET);
    cmd.clr_row   = (state == S_CLR);
    cmd.build     = (state == S_DISPATCH) && !stat.is_query && !stat.is_clear;
    cmd.op_rd     = (state == S_WRD) && stat.op_pend;
    cmd.op_wb     = (state == S_WWB);
    cmd.scan_init = (state == S_DISPATCH) && stat.is_query;
    cmd.scan_row  = (state == S_SCAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RESET;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_RESET: state <= S_CLR;
        S_CLR: begin
          if (m_tvalid && m_tready) m_tvalid <= 1'b0;
          if (stat.clr_last) begin
            if (m_tvalid && !m_tready) state <= S_OUT;
            else state <= S_IDLE;
          end
        end
        S_IDLE: if (s_tvalid) state <= S_DISPATCH;
        S_DISPATCH: begin
          if (stat.is_query) state <= S_SCAN;
          else if (stat.is_clear) begin
            state    <= S_CLR;
            m_tvalid <= 1'b1;
          end else begin
            state <= S_WRD;
          end
        end
        S_WRD: begin
          if (stat.op_pend) state <= S_WWB;
          else begin
            state    <= S_OUT;
            m_tvalid <= 1'b1;
          end
        end
        S_WWB: state <= S_WRD;
        S_SCAN: if (stat.scan_done) begin
          state    <= S_OUT;
          m_tvalid <= 1'b1;
        end
        S_OUT: if (m_tready) begin
          m_tvalid <= 1'b0;
          state    <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/tnfa_dp.sv
`default_nettype none
module tnfa_dp #(
  parameter int MAX_STATES  = 64,
  parameter int STACK_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic [79:0]        in_word,
  input  wire tnfa_pkg::dp_cmd_t  cmd,
  output tnfa_pkg::dp_stat_t      stat,
  output logic [87:0]             out_word
);
  localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int PW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [63:0] lam [MAX_STATES];
  logic [14:0] sym_mem [MAX_STATES];  // valid, character, target
  logic [63:0] lam_q;
  logic [14:0] sym_q;
  logic [5:0] fs_s [STACK_DEPTH];
  logic [5:0] fs_a [STACK_DEPTH];
  logic [6:0] sp;
  logic [6:0] nsi;

  logic [1:0]    c_cmd;
  logic [7:0]    c_sym;
  logic [63:0]   c_q;
  logic [SW:0]   row;
  logic [SW-1:0] row_ix;
  logic [63:0]   set_r, pend;
  logic [1:0]    status;
  logic          hit;
  logic          cph;

  // lambda row updates of one build, applied a row at a time
  logic [SW-1:0] op_a [3];
  logic [63:0]   op_m [3];
  logic [1:0]    op_n, op_i;

  logic [63:0] smask;
  always_comb begin
    smask = '0;
    for (int k = 0; k < 64; k++) smask[k] = (k < MAX_STATES);
  end

  assign row_ix = row[SW-1:0];
  assign stat.is_query = (c_cmd == tnfa_pkg::CMD_CLOSURE) || (c_cmd == tnfa_pkg::CMD_STEP);
  assign stat.is_clear = (c_cmd == tnfa_pkg::CMD_CLEAR);
  assign stat.clr_last = (row == (SW+1)'(MAX_STATES - 1));
  assign stat.op_pend  = (op_i != op_n);

  // lowest pending bit
  logic [5:0] lo;
  logic       any;
  always_comb begin
    lo = '0;
    any = 1'b0;
    for (int k = 63; k >= 0; k--) if (pend[k]) begin
      lo = 6'(k);
      any = 1'b1;
    end
  end
  logic closure_m;
  assign closure_m = (c_cmd == tnfa_pkg::CMD_CLOSURE);
  assign stat.scan_done = closure_m ? (!cph && !any) : (row == (SW+1)'(MAX_STATES));

  // build decode
  logic alnum, binop, unop;
  logic [PW-1:0] t1, t2;
  logic [5:0] a_s, a_a, b_s, b_a, n0, n1;
  assign alnum = tnfa_pkg::is_alnum(c_sym);
  assign binop = (c_sym == tnfa_pkg::CH_CAT) || (c_sym == tnfa_pkg::CH_ALT);
  assign unop  = (c_sym == tnfa_pkg::CH_STAR) || (c_sym == tnfa_pkg::CH_PLUS);
  assign t1 = PW'(sp - 7'd1);
  assign t2 = PW'(sp - 7'd2);
  assign a_s = fs_s[t2]; assign a_a = fs_a[t2];
  assign b_s = fs_s[t1]; assign b_a = fs_a[t1];
  assign n0 = nsi[5:0];
  assign n1 = 6'(nsi + 7'd1);
  logic full;
  assign full = (nsi + 7'd2) > 7'(MAX_STATES);
  logic new_leaf;
  assign new_leaf = cmd.build && alnum && (sp < 7'(STACK_DEPTH)) && !full;

  function automatic logic [63:0] bit_of(input logic [5:0] s);
    return 64'd1 << s;
  endfunction

  // edge tables: one registered read and one write a cycle
  logic [SW-1:0] lam_ra, lam_wa, sym_wa;
  logic          lam_we, sym_we;
  logic [63:0]   lam_wd;
  logic [14:0]   sym_wd;
  always_comb begin
    if (cmd.op_rd) lam_ra = op_a[op_i];
    else if (closure_m) lam_ra = lo[SW-1:0];
    else lam_ra = row_ix;
    lam_we = cmd.clr_row || cmd.op_wb;
    lam_wa = cmd.op_wb ? op_a[op_i] : row_ix;
    lam_wd = cmd.op_wb ? (lam_q | op_m[op_i]) : '0;
    sym_we = cmd.clr_row || new_leaf;
    sym_wa = new_leaf ? n0[SW-1:0] : row_ix;
    sym_wd = new_leaf ? {1'b1, c_sym, n1} : '0;
  end

  always_ff @(posedge clk) begin
    if (lam_we) lam[lam_wa] <= lam_wd;
    lam_q <= lam[lam_ra];
  end

  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_wa] <= sym_wd;
    sym_q <= sym_mem[lam_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_cmd <= in_word[1:0];
      c_sym <= in_word[9:2];
      c_q   <= in_word[73:10];
    end
    if (cmd.clr_init) begin
      row <= '0;
      sp  <= '0;
      nsi <= '0;
      status <= tnfa_pkg::ST_OK;
      set_r <= '0;
    end else if (cmd.clr_row) begin
      row <= row + (SW+1)'(1);
    end else if (cmd.scan_init) begin
      row <= '0;
      hit <= 1'b0;
      cph <= 1'b0;
      status <= tnfa_pkg::ST_OK;
      set_r <= closure_m ? (c_q & smask) : '0;
      pend  <= c_q & smask;
    end else if (cmd.scan_row) begin
      if (closure_m) begin
        if (!cph) begin
          if (any) begin
            pend <= pend & ~bit_of(lo);
            cph  <= 1'b1;
          end
        end else begin
          pend  <= pend | (lam_q & ~set_r);
          set_r <= set_r | lam_q;
          cph   <= 1'b0;
        end
      end else begin
        if (row != (SW+1)'(MAX_STATES)) row <= row + (SW+1)'(1);
        hit <= (row != (SW+1)'(MAX_STATES)) && pend[row_ix];
        if (hit) begin
          if (c_sym == 8'd0) set_r <= set_r | (lam_q & smask);
          else if (sym_q[14] && sym_q[13:6] == c_sym)
            set_r <= set_r | (bit_of(sym_q[5:0]) & smask);
        end
      end
    end else if (cmd.op_wb) begin
      op_i <= op_i + 2'd1;
    end else if (cmd.build) begin
      set_r <= '0;
      op_i  <= '0;
      if (alnum) begin
        op_n <= 2'd0;
        if (sp >= 7'(STACK_DEPTH)) status <= tnfa_pkg::ST_STACK;
        else if (full) status <= tnfa_pkg::ST_FULL;
        else begin
          status <= tnfa_pkg::ST_OK;
          fs_s[PW'(sp)] <= n0;
          fs_a[PW'(sp)] <= n1;
          sp  <= sp + 7'd1;
          nsi <= nsi + 7'd2;
        end
      end else if (!binop && !unop) begin
        status <= tnfa_pkg::ST_OK;
        op_n   <= 2'd0;
      end else if (sp < (binop ? 7'd2 : 7'd1)) begin
        status <= tnfa_pkg::ST_UNDER;
        op_n   <= 2'd0;
      end else if (c_sym == tnfa_pkg::CH_CAT) begin
        status  <= tnfa_pkg::ST_OK;
        op_n    <= 2'd1;
        op_a[0] <= a_a[SW-1:0];
        op_m[0] <= bit_of(b_s);
        fs_a[t2] <= b_a;
        sp <= sp - 7'd1;
      end else if (full) begin
        status <= tnfa_pkg::ST_FULL;
        op_n   <= 2'd0;
      end else if (c_sym == tnfa_pkg::CH_ALT) begin
        // new rows start clear, so every update is an OR into its row
        status  <= tnfa_pkg::ST_OK;
        op_n    <= 2'd3;
        op_a[0] <= n0[SW-1:0];
        op_m[0] <= bit_of(a_s) | bit_of(b_s);
        op_a[1] <= a_a[SW-1:0];
        op_m[1] <= bit_of(n1);
        op_a[2] <= b_a[SW-1:0];
        op_m[2] <= bit_of(n1);
        fs_s[t2] <= n0;
        fs_a[t2] <= n1;
        sp  <= sp - 7'd1;
        nsi <= nsi + 7'd2;
      end else begin
        status  <= tnfa_pkg::ST_OK;
        op_n    <= 2'd2;
        op_a[0] <= n0[SW-1:0];
        op_m[0] <= bit_of(b_s) |
                   ((c_sym == tnfa_pkg::CH_STAR) ? bit_of(n1) : 64'd0);
        op_a[1] <= b_a[SW-1:0];
        op_m[1] <= bit_of(b_s) | bit_of(n1);
        fs_s[t1] <= n0;
        fs_a[t1] <= n1;
        nsi <= nsi + 7'd2;
      end
    end
  end

  logic [5:0] top_s, top_a;
  always_comb begin
    top_s = '0;
    top_a = '0;
    if (sp != 7'd0 && sp <= 7'(STACK_DEPTH)) begin
      top_s = fs_s[t1];
      top_a = fs_a[t1];
    end
  end
  assign out_word = {4'b0000, sp[5:0], top_a, top_s, set_r, status};
endmodule
`default_nettype wire

FILE: rtl/core/tnfa_checker.sv
`default_nettype none
module tnfa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [87:0] m_tdata
);
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken with result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_depth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[87:84] == 4'd0) else $error("pad nonzero");
  a_accept_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("back to back accept");
endmodule

bind thompson_nfa_builder tnfa_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire
